// File: hdl/nalspl_pkg.sv
// Shared types, constants and helpers of the Annex B NAL unit splitter.
package nalspl_pkg;

  // Default widths of the length and sample counters
  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned CountBitsDef  = 32;

  // NAL header decoding
  localparam logic [4:0] TypeMask = 5'h1F;
  localparam logic [4:0] TypeSps  = 5'd7;
  localparam logic [4:0] TypePps  = 5'd8;
  localparam int unsigned SpsHead = 4;

  // Most zeros held back while looking for a start code
  localparam logic [1:0] MaxHeldZeros = 2'd3;

  // Command queue between front and back end
  localparam int unsigned CmdDepth    = 4;
  localparam int unsigned CmdPtrBits  = $clog2(CmdDepth);
  localparam int unsigned CmdCntBits  = $clog2(CmdDepth + 1);

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DESC    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ROUTE_VIDEO = 2'd0,
    ROUTE_SPS   = 2'd1,
    ROUTE_PPS   = 2'd2
  } route_e;

  // Input request: one byte of the Annex B stream
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } item_t;

  // Output request: one payload byte or one end-of-NAL descriptor
  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  payload_byte;
    logic [4:0]  unit_type;
    route_e      route;
    logic [23:0] unit_length;
    logic [31:0] samples_so_far;
    logic [7:0]  profile_byte;
    logic [7:0]  compat_byte;
    logic [7:0]  level_byte;
    logic        params_ready;
    logic        last_of_run;
  } result_t;

  // Work for the back end: zeros to release, an optional byte, an optional close
  typedef struct packed {
    logic [1:0] zeros;
    logic       emit;
    logic [7:0] data;
    logic       close;
  } cmd_t;

  function automatic route_e route_of(input logic [4:0] unit_type);
    route_e r;
    if (unit_type == TypeSps) begin
      r = ROUTE_SPS;
    end else if (unit_type == TypePps) begin
      r = ROUTE_PPS;
    end else begin
      r = ROUTE_VIDEO;
    end
    return r;
  endfunction

endpackage

// File: hdl/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter.
// An input byte is accepted in every cycle in which the four-entry command queue between the
// front and back end has room, so bursts of stream bytes go in at one per cycle. The back end
// issues one result per cycle while its output register is empty or being popped: a byte gives
// between zero and five results (released zeros, the byte itself, a descriptor), and a start code
// that closes an empty NAL takes a step with no result. Sustained input rate is therefore one byte
// per result produced, which for ordinary NAL payload is one byte per cycle. Results leave through
// a single output register that is refilled in the cycle it is popped.
module annexb_nal_unit_splitter #(
  parameter int unsigned LENGTH_BITS = nalspl_pkg::LengthBitsDef,
  parameter int unsigned COUNT_BITS  = nalspl_pkg::CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  nalspl_pkg::item_t   item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output nalspl_pkg::result_t result_o
);
  import nalspl_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic front_cmd_valid, head_valid, head_done, accept;

  assign accept = push && !full;

  nalspl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cmd_valid_o (front_cmd_valid),
    .cmd_o       (front_cmd)
  );

  nalspl_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_cmd_valid),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (head_done),
    .valid_o   (head_valid),
    .rd_data_o (head_cmd)
  );

  nalspl_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_done_o  (head_done),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

// File: hdl/nalspl_front.sv
// Front end: tracks held zeros and turns stream bytes into commands.
module nalspl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  nalspl_pkg::item_t   item_i,
  output logic                cmd_valid_o,
  output nalspl_pkg::cmd_t    cmd_o
);
  import nalspl_pkg::*;

  logic [1:0] held_q, held_d;
  cmd_t       cmd;

  // Classify the byte against the held zero run
  always_comb begin
    held_d     = held_q;
    cmd.zeros  = 2'd0;
    cmd.emit   = 1'b0;
    cmd.data   = item_i.stream_byte;
    cmd.close  = item_i.buffer_end;
    if (item_i.stream_byte == 8'h00) begin
      if (held_q < MaxHeldZeros) begin
        // hold the zero, or release the whole run at buffer end
        if (item_i.buffer_end) begin
          cmd.zeros = held_q + 2'd1;
          held_d    = 2'd0;
        end else begin
          held_d    = held_q + 2'd1;
        end
      end else begin
        // fourth zero: release the oldest into the NAL; all at buffer end
        cmd.emit = 1'b1;
        if (item_i.buffer_end) begin
          cmd.zeros = MaxHeldZeros;
          held_d    = 2'd0;
        end
      end
    end else if (item_i.stream_byte == 8'h01 && held_q >= 2'd2) begin
      // start code: drop the zeros and close the open NAL
      held_d    = 2'd0;
      cmd.close = 1'b1;
    end else begin
      // ordinary byte: release held zeros, then the byte itself
      cmd.zeros = held_q;
      cmd.emit  = 1'b1;
      held_d    = 2'd0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.zeros != 2'd0 || cmd.emit || cmd.close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'd0;
    end else if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// File: hdl/nalspl_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module nalspl_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  nalspl_pkg::cmd_t   wr_data_i,
  output logic               full_o,
  input  logic               rd_i,
  output logic               valid_o,
  output nalspl_pkg::cmd_t   rd_data_o
);
  import nalspl_pkg::*;

  cmd_t                  slot_q [CmdDepth];
  logic [CmdPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntBits-1:0] count_q;
  logic                  do_wr, do_rd;

  assign full_o    = (count_q == CmdCntBits'(CmdDepth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = slot_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrBits'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrBits'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (!do_wr && do_rd) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hdl/nalspl_back.sv
// Back end: runs commands a step a cycle unless stalled; NAL state, results.
module nalspl_back #(
  parameter int unsigned LENGTH_BITS = nalspl_pkg::LengthBitsDef,
  parameter int unsigned COUNT_BITS  = nalspl_pkg::CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  nalspl_pkg::cmd_t    cmd_i,
  output logic                cmd_done_o,
  output logic                empty,
  input  logic                pop,
  output nalspl_pkg::result_t result_o
);
  import nalspl_pkg::*;

  logic [2:0]             step_q, step_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [4:0]             type_q, type_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [23:0]            pend_q, pend_d;
  logic [23:0]            commit_q, commit_d;
  logic                   sps_q, sps_d;
  logic                   pps_q, pps_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;

  logic       do_step;
  logic       act_zero, act_byte, act_close, final_step;
  logic [2:0] zeros_w;
  logic [7:0] b_act;
  logic [31:0] len_wide;

  assign zeros_w   = {1'b0, cmd_i.zeros};
  assign act_zero  = step_q < zeros_w;
  assign act_byte  = !act_zero && cmd_i.emit && (step_q == zeros_w);
  assign act_close = !act_zero && !act_byte;
  assign b_act     = act_zero ? 8'h00 : cmd_i.data;
  assign len_wide  = 32'(len_q);

  // Last step of the command: it pops the queue and marks the run end
  assign final_step = act_close
                   || (act_byte && !cmd_i.close)
                   || (act_zero && (step_q == zeros_w - 3'd1) && !cmd_i.emit && !cmd_i.close);

  assign do_step    = cmd_valid_i && (!out_valid_q || pop);
  assign cmd_done_o = do_step && final_step;

  // Execute one step of the head command
  always_comb begin
    step_d      = step_q;
    len_d       = len_q;
    type_d      = type_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    commit_d    = commit_q;
    sps_d       = sps_q;
    pps_d       = pps_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;

    if (do_step) begin
      step_d = final_step ? 3'd0 : step_q + 3'd1;
      if (!act_close) begin
        // payload byte: open the NAL on its first byte, capture SPS head
        if (len_q == '0) begin
          type_d = b_act[4:0] & TypeMask;
          pend_d = '0;
        end
        if (type_d == TypeSps) begin
          if (len_q == LENGTH_BITS'(1)) begin
            pend_d[23:16] = b_act;
          end else if (len_q == LENGTH_BITS'(2)) begin
            pend_d[15:8] = b_act;
          end else if (len_q == LENGTH_BITS'(3)) begin
            pend_d[7:0] = b_act;
          end
        end
        if (!(&len_q)) begin
          len_d = len_q + 1'b1;
        end
        out_valid_d          = 1'b1;
        out_d.result_kind    = KIND_PAYLOAD;
        out_d.payload_byte   = b_act;
        out_d.unit_type      = type_d;
        out_d.route          = route_of(type_d);
        out_d.unit_length    = '0;
        out_d.samples_so_far = 32'(cnt_q);
        out_d.profile_byte   = commit_q[23:16];
        out_d.compat_byte    = commit_q[15:8];
        out_d.level_byte     = commit_q[7:0];
        out_d.params_ready   = sps_q && pps_q;
        out_d.last_of_run    = final_step;
      end else if (len_q != '0) begin
        // close a non-empty NAL and emit its descriptor
        if (type_q == TypeSps) begin
          sps_d    = 1'b1;
          commit_d = (len_q >= LENGTH_BITS'(SpsHead)) ? pend_q : '0;
        end else if (type_q == TypePps) begin
          pps_d = 1'b1;
        end else if (!(&cnt_q)) begin
          cnt_d = cnt_q + 1'b1;
        end
        out_valid_d          = 1'b1;
        out_d.result_kind    = KIND_DESC;
        out_d.payload_byte   = 8'h00;
        out_d.unit_type      = type_q;
        out_d.route          = route_of(type_q);
        out_d.unit_length    = len_wide[23:0];
        out_d.samples_so_far = 32'(cnt_d);
        out_d.profile_byte   = commit_d[23:16];
        out_d.compat_byte    = commit_d[15:8];
        out_d.level_byte     = commit_d[7:0];
        out_d.params_ready   = sps_d && pps_d;
        out_d.last_of_run    = 1'b1;
        len_d                = '0;
        type_d               = '0;
        pend_d               = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      len_q       <= '0;
      type_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= '0;
      commit_q    <= '0;
      sps_q       <= 1'b0;
      pps_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      len_q       <= len_d;
      type_q      <= type_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      commit_q    <= commit_d;
      sps_q       <= sps_d;
      pps_q       <= pps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until it is popped
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// File: tb/sv/annexb_nal_unit_splitter_tb.sv
// Testbench of the Annex B NAL unit splitter: directed and random byte streams, checked result by result.
`timescale 1ns / 100ps

module annexb_nal_unit_splitter_tb;
  import nalspl_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [23:0] LenMax       = 24'hFF_FFFF;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push   = 1'b0;
  logic    pop    = 1'b0;
  item_t   stream_item = '0;
  logic    full;
  logic    empty;
  result_t result_o;

  // Splitter state as predicted from the accepted bytes
  logic [1:0]  zeros_held    = '0;
  logic [23:0] nal_len       = '0;
  logic [4:0]  open_type     = '0;
  logic [31:0] video_count   = '0;
  logic [23:0] sps_pending   = '0;
  logic [23:0] sps_committed = '0;
  logic        sps_done      = 1'b0;
  logic        pps_done      = 1'b0;

  result_t     nal_results_q[$];
  logic [7:0]  buffer_bytes[$];
  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  logic        sender_idles = 1'b1;
  logic [9:0]  pop_tick    = '0;

  annexb_nal_unit_splitter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .item_i  (stream_item),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic route_e route_for(logic [4:0] t);
    route_e r;
    case (t)
      TypeSps: r = ROUTE_SPS;
      TypePps: r = ROUTE_PPS;
      default: r = ROUTE_VIDEO;
    endcase
    return r;
  endfunction

  function automatic void add_result(kind_e kind, logic [7:0] data, logic [23:0] len);
    result_t r;
    r.result_kind    = kind;
    r.payload_byte   = data;
    r.unit_type      = open_type;
    r.route          = route_for(open_type);
    r.unit_length    = len;
    r.samples_so_far = video_count;
    r.profile_byte   = sps_committed[23:16];
    r.compat_byte    = sps_committed[15:8];
    r.level_byte     = sps_committed[7:0];
    r.params_ready   = sps_done & pps_done;
    r.last_of_run    = 1'b0;
    nal_results_q.push_back(r);
  endfunction

  // Append one byte to the open NAL; the first byte fixes its type
  function automatic void add_nal_byte(logic [7:0] b);
    if (nal_len == 0) begin
      open_type   = b[4:0] & TypeMask;
      sps_pending = '0;
    end
    if (open_type == TypeSps && nal_len >= 1 && nal_len <= 3) begin
      sps_pending = sps_pending | (24'(b) << ((3 - nal_len) * 8));
    end
    if (nal_len != LenMax) nal_len++;
    add_result(KIND_PAYLOAD, b, '0);
  endfunction

  function automatic void release_zeros();
    while (zeros_held != 0) begin
      add_nal_byte(8'h00);
      zeros_held--;
    end
  endfunction

  // Close the open NAL; an empty one leaves no trace
  function automatic void finish_nal();
    if (nal_len == 0) return;
    if (open_type == TypeSps) begin
      sps_done      = 1'b1;
      sps_committed = (nal_len >= SpsHead) ? sps_pending : '0;
    end else if (open_type == TypePps) begin
      pps_done = 1'b1;
    end else if (video_count != '1) begin
      video_count++;
    end
    add_result(KIND_DESC, 8'h00, nal_len);
    nal_len     = '0;
    open_type   = '0;
    sps_pending = '0;
  endfunction

  function automatic void split_byte(logic [7:0] b, logic buf_end);
    int unsigned start_size;
    start_size = nal_results_q.size();
    if (b == 8'h00) begin
      if (zeros_held < MaxHeldZeros) zeros_held++;
      else add_nal_byte(8'h00);
    end else if (b == 8'h01 && zeros_held >= 2) begin
      zeros_held = '0;
      finish_nal();
    end else begin
      release_zeros();
      add_nal_byte(b);
    end
    if (buf_end) begin
      release_zeros();
      finish_nal();
    end
    if (nal_results_q.size() > start_size) begin
      nal_results_q[nal_results_q.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic string show(result_t r);
    return $sformatf({"kind=%0d byte=%02h type=%0d route=%0d len=%0d samples=%0d ",
                      "sps=%02h%02h%02h ready=%0b last=%0b"},
                     r.result_kind, r.payload_byte, r.unit_type, r.route, r.unit_length,
                     r.samples_so_far, r.profile_byte, r.compat_byte, r.level_byte,
                     r.params_ready, r.last_of_run);
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    logic    bad;
    if (rst_ni && pop && !empty) begin
      if (nal_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("unexpected result: %s", show(result_o));
        end
      end else begin
        want = nal_results_q.pop_front();
        bad = (result_o.result_kind    !== want.result_kind)    ||
              (result_o.payload_byte   !== want.payload_byte)   ||
              (result_o.unit_type      !== want.unit_type)      ||
              (result_o.route          !== want.route)          ||
              (result_o.unit_length    !== want.unit_length)    ||
              (result_o.samples_so_far !== want.samples_so_far) ||
              (result_o.profile_byte   !== want.profile_byte)   ||
              (result_o.compat_byte    !== want.compat_byte)    ||
              (result_o.level_byte     !== want.level_byte)     ||
              (result_o.params_ready   !== want.params_ready)   ||
              (result_o.last_of_run    !== want.last_of_run);
        if (bad) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("result differs\n  expected %s\n  actual   %s", show(want), show(result_o));
          end
        end
      end
    end
  end

  // Stall the result side in phases: steady, random, sparse, mostly ready
  always @(negedge clk_i) begin
    pop_tick <= pop_tick + 1'b1;
    case (pop_tick[9:8])
      2'd0:    pop <= 1'b1;
      2'd1:    pop <= 1'($urandom_range(0, 1));
      2'd2:    pop <= (pop_tick[1:0] == 2'd0);
      default: pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("annexb_nal_unit_splitter: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one request in bursts with random gaps; push stays high across a burst
  task automatic send_item(logic [7:0] b, logic buf_end);
    item_t next_item;
    if (sender_idles && burst_left == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    next_item.stream_byte = b;
    next_item.buffer_end  = buf_end;
    @(negedge clk_i);
    push        <= 1'b1;
    stream_item <= next_item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    split_byte(b, buf_end);
    items_sent++;
  endtask

  // Send the held buffer, flagging its last byte
  task automatic send_buffer_bytes();
    int i;
    for (i = 0; i < buffer_bytes.size(); i++) begin
      send_item(buffer_bytes[i], i == buffer_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (nal_results_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0, 1:    b = 8'h00;
      2:       b = 8'h01;
      3:       b = 8'h03;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Build one encoder buffer of start-code framed NALs with random content
  task automatic build_random_buffer();
    int         i;
    int         j;
    int         unit_total;
    int         body_len;
    logic [4:0] t;
    buffer_bytes.delete();
    unit_total = $urandom_range(1, 4);
    for (i = 0; i < unit_total; i++) begin
      if (!(i == 0 && $urandom_range(0, 7) == 0)) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'h00);
        end
        repeat ($urandom_range(2, 3)) buffer_bytes.push_back(8'h00);
        buffer_bytes.push_back(8'h01);
      end
      if ($urandom_range(0, 15) == 0) continue;
      case ($urandom_range(0, 7))
        0:       t = 5'd1;
        1:       t = 5'd5;
        2, 3:    t = TypeSps;
        4:       t = TypePps;
        5:       t = 5'd6;
        6:       t = 5'd9;
        default: t = 5'($urandom_range(0, 31));
      endcase
      buffer_bytes.push_back({3'($urandom_range(0, 7)), t});
      if ($urandom_range(0, 15) == 0) body_len = $urandom_range(20, 40);
      else if (t == TypeSps) body_len = $urandom_range(0, 6);
      else body_len = $urandom_range(0, 10);
      for (j = 0; j < body_len; j++) buffer_bytes.push_back(body_byte());
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'h00);
    end
    if (buffer_bytes.size() == 0) buffer_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Unframed bytes with stray buffer ends
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      send_item(body_byte(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        send_noise();
      end else begin
        build_random_buffer();
        send_buffer_bytes();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Buffer with no leading start code; 01 without zeros is payload
  task automatic test_no_start_code();
    buffer_bytes = '{8'h65, 8'h01, 8'hFF};
    send_buffer_bytes();
  endtask

  // Four-byte start code, full SPS, three-byte start code, PPS
  task automatic test_param_sets();
    buffer_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'hC0, 8'h1F,
                     8'h00, 8'h00, 8'h01, 8'h68, 8'hCE};
    send_buffer_bytes();
  endtask

  // Long zero run, empty NAL between start codes, short SPS closed on held zero
  task automatic test_zero_runs();
    buffer_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'h00, 8'h00, 8'h01, 8'h67, 8'h00};
    send_buffer_bytes();
  endtask

  // Start code right before the buffer end
  task automatic test_empty_at_end();
    buffer_bytes = '{8'h00, 8'h00, 8'h01};
    send_buffer_bytes();
  endtask

  task automatic test_random_buffers();
    sender_idles = 1'b1;
    run_random(110);
  endtask

  // Hold the sender until every result is out, then carry on
  task automatic test_drain_pause();
    run_random(30);
    wait_drained();
    run_random(30);
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    run_random(80);
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_no_start_code();
    test_param_sets();
    test_zero_runs();
    test_empty_at_end();
    test_random_buffers();
    test_drain_pause();
    test_back_to_back();

    // Let the last results out, then allow for trailing work
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("annexb_nal_unit_splitter: match");
    end else begin
      $display("annexb_nal_unit_splitter: mismatch");
    end
    $finish;
  end

endmodule
